/* rtl/tch_pkg.sv */
// Shared types and constants for the tilt-compensated heading pipeline.
// Holds the fixed-point angle constants and the CORDIC arctangent table.
// No dependencies.
package tch_pkg;

  // Widths of the input fields and of the internal datapath.
  localparam int ANGLE_W = 16;             // Q3.13 angles and raw magnetometer samples
  localparam int ZW      = 34;             // Q30 angle accumulator, holds +/- 2^33
  localparam int TW      = 32;             // Q30 sine and cosine
  localparam int MAX_STEPS = 24;           // deepest CORDIC supported by the table

  // Q30 angle constants.
  localparam logic signed [ZW-1:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [ZW-1:0] TWO_PI_Q30  = 34'sd6746518852;
  // CORDIC start value: 1/K for infinitely many steps, in Q30.
  localparam logic signed [ZW-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;
  // Half an LSB of Q13 expressed in Q30, for round half up.
  localparam logic signed [ZW-1:0] ROUND_Q30 = 34'sd65536;
  // A full turn in Q13; a rounded heading of this value wraps to zero.
  localparam logic [ANGLE_W-1:0] TWO_PI_Q13 = 16'd51472;

  // atan(2^-i) in Q30, rounded half up.
  localparam logic [31:0] ATAN_Q30 [0:MAX_STEPS-1] = '{
    32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159,
    32'd67021687,  32'd33543516,  32'd16775851,  32'd8388437,
    32'd4194283,   32'd2097149,   32'd1048576,   32'd524288,
    32'd262144,    32'd131072,    32'd65536,     32'd32768,
    32'd16384,     32'd8192,      32'd4096,      32'd2048,
    32'd1024,      32'd512,       32'd256,       32'd128
  };

  // An input angle folded into the CORDIC convergence range.
  typedef struct packed {
    logic signed [ZW-1:0] z;    // folded angle, Q30
    logic                 neg;  // sine and cosine must be negated afterwards
  } fold_t;

  // Scale a Q3.13 angle to Q30 and fold it to within a quarter turn.
  function automatic fold_t fold_angle(input logic signed [ANGLE_W-1:0] a);
    fold_t                f;
    logic signed [ZW-1:0] z;
    z = {{(ZW-ANGLE_W-17){a[ANGLE_W-1]}}, a, 17'b0};
    f.neg = 1'b0;
    f.z   = z;
    if (z > HALF_PI_Q30) begin
      f.z   = z - PI_Q30;
      f.neg = 1'b1;
    end else if (z < -HALF_PI_Q30) begin
      f.z   = z + PI_Q30;
      f.neg = 1'b1;
    end
    return f;
  endfunction

  // Arctangent table entry widened to the angle accumulator.
  function automatic logic signed [ZW-1:0] atan_z(input int i);
    return $signed({{(ZW-32){1'b0}}, ATAN_Q30[i]});
  endfunction

endpackage

/* rtl/tilt_compensated_heading.sv */
// Tilt-compensated magnetic heading: a fully pipelined fixed-point datapath.
// Depends on tch_pkg (angle constants, arctangent table, angle folding).
//
// The block takes roll and pitch in signed Q3.13 radians together with one raw
// three-axis magnetometer sample and returns the magnetic heading in unsigned
// Q3.13 radians, wrapped to 0 .. just below 2pi. Sine and cosine of both angles
// come from two rotation-mode CORDICs running side by side, one iteration per
// pipeline stage; the horizontal field components are formed in three
// multiply/add stages; atan2(-hy, hx) comes from a vectoring-mode CORDIC, again
// one iteration per stage. While the skid register is empty the pipeline takes a
// new beat every clock cycle; it delivers one result beat per input beat, in order.
// An accepted beat passes the entry, rotation, trig, first and second multiply, sum,
// pre-rotation, vectoring and output stages in that order. A single skid register
// behind the last stage lets the input keep taking a beat while a finished result
// waits for out_ready; the whole pipeline holds only once that skid register is
// occupied. A zero horizontal vector gives heading zero. The block keeps no state
// between beats; reset only clears valid bits.
module tilt_compensated_heading #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic signed [tch_pkg::ANGLE_W-1:0] roll_angle,
  input  logic signed [tch_pkg::ANGLE_W-1:0] pitch_angle,
  input  logic signed [tch_pkg::ANGLE_W-1:0] mag_x,
  input  logic signed [tch_pkg::ANGLE_W-1:0] mag_y,
  input  logic signed [tch_pkg::ANGLE_W-1:0] mag_z,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [tch_pkg::ANGLE_W-1:0] heading
);
  import tch_pkg::*;

  localparam int N   = CORDIC_STEPS;
  localparam int PW  = 2 * TW;             // sin*sin product, Q60
  localparam int MPW = ANGLE_W + TW;       // sample times Q30 factor
  localparam int HW  = MPW + 1;            // hy, sum of two products
  localparam int VW  = MPW + 4;            // vectoring x/y with pre-rotation and gain
  localparam int FW  = ZW + 2;             // wrapped and rounded heading sum

  // The whole pipeline moves together unless the skid register is occupied.
  logic adv;
  logic skid_full;

  assign adv      = !skid_full;
  assign in_ready = adv;

  // ------------------------------------------------------------------
  // Entry stage: scale both angles to Q30 and fold them to a quarter turn.
  // Index 0 of the rotation arrays holds the CORDIC start vectors.
  // ------------------------------------------------------------------
  fold_t roll_f, pitch_f;

  always_comb begin
    roll_f  = fold_angle(roll_angle);
    pitch_f = fold_angle(pitch_angle);
  end

  logic                      rv   [0:N];
  logic signed [ZW-1:0]      rx   [0:N];
  logic signed [ZW-1:0]      ry   [0:N];
  logic signed [ZW-1:0]      rz   [0:N];
  logic                      rneg [0:N];
  logic signed [ZW-1:0]      px   [0:N];
  logic signed [ZW-1:0]      py   [0:N];
  logic signed [ZW-1:0]      pz   [0:N];
  logic                      pneg [0:N];
  logic signed [ANGLE_W-1:0] mx_s [0:N];
  logic signed [ANGLE_W-1:0] my_s [0:N];
  logic signed [ANGLE_W-1:0] mz_s [0:N];

  // ------------------------------------------------------------------
  // Rotation CORDIC for roll and pitch: stage k performs iteration k-1.
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= N; k++) begin
        rv[k] <= 1'b0;
      end
    end else if (adv) begin
      rv[0] <= in_valid;
      for (int k = 1; k <= N; k++) begin
        rv[k] <= rv[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rx[0]   <= CORDIC_GAIN_Q30;
      ry[0]   <= '0;
      rz[0]   <= roll_f.z;
      rneg[0] <= roll_f.neg;
      px[0]   <= CORDIC_GAIN_Q30;
      py[0]   <= '0;
      pz[0]   <= pitch_f.z;
      pneg[0] <= pitch_f.neg;
      mx_s[0] <= mag_x;
      my_s[0] <= mag_y;
      mz_s[0] <= mag_z;
      for (int k = 1; k <= N; k++) begin
        if (rz[k-1] >= 0) begin
          rx[k] <= rx[k-1] - (ry[k-1] >>> (k - 1));
          ry[k] <= ry[k-1] + (rx[k-1] >>> (k - 1));
          rz[k] <= rz[k-1] - atan_z(k - 1);
        end else begin
          rx[k] <= rx[k-1] + (ry[k-1] >>> (k - 1));
          ry[k] <= ry[k-1] - (rx[k-1] >>> (k - 1));
          rz[k] <= rz[k-1] + atan_z(k - 1);
        end
        if (pz[k-1] >= 0) begin
          px[k] <= px[k-1] - (py[k-1] >>> (k - 1));
          py[k] <= py[k-1] + (px[k-1] >>> (k - 1));
          pz[k] <= pz[k-1] - atan_z(k - 1);
        end else begin
          px[k] <= px[k-1] + (py[k-1] >>> (k - 1));
          py[k] <= py[k-1] - (px[k-1] >>> (k - 1));
          pz[k] <= pz[k-1] + atan_z(k - 1);
        end
        rneg[k] <= rneg[k-1];
        pneg[k] <= pneg[k-1];
        mx_s[k] <= mx_s[k-1];
        my_s[k] <= my_s[k-1];
        mz_s[k] <= mz_s[k-1];
      end
    end
  end

  // ------------------------------------------------------------------
  // Trig stage: undo the half-turn fold by negating sine and cosine.
  // ------------------------------------------------------------------
  logic signed [ZW-1:0] sr_next, cr_next, sp_next, cp_next;

  always_comb begin
    sr_next = rneg[N] ? -ry[N] : ry[N];
    cr_next = rneg[N] ? -rx[N] : rx[N];
    sp_next = pneg[N] ? -py[N] : py[N];
    cp_next = pneg[N] ? -px[N] : px[N];
  end

  logic                      tv;
  logic signed [TW-1:0]      sr, cr, sp, cp;
  logic signed [ANGLE_W-1:0] mx_t, my_t, mz_t;

  always_ff @(posedge clk) begin
    if (rst) begin
      tv <= 1'b0;
    end else if (adv) begin
      tv <= rv[N];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sr   <= $signed(sr_next[TW-1:0]);
      cr   <= $signed(cr_next[TW-1:0]);
      sp   <= $signed(sp_next[TW-1:0]);
      cp   <= $signed(cp_next[TW-1:0]);
      mx_t <= mx_s[N];
      my_t <= my_s[N];
      mz_t <= mz_s[N];
    end
  end

  // ------------------------------------------------------------------
  // First multiply stage: pitch/roll cross terms and the plain products.
  // ------------------------------------------------------------------
  logic                      m1v;
  logic signed [PW-1:0]      p_spsr, p_spcr;
  logic signed [MPW-1:0]     p_mxcp, p_mycr, p_mzsr;
  logic signed [ANGLE_W-1:0] my_m, mz_m;

  always_ff @(posedge clk) begin
    if (rst) begin
      m1v <= 1'b0;
    end else if (adv) begin
      m1v <= tv;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_spsr <= PW'(sp) * PW'(sr);
      p_spcr <= PW'(sp) * PW'(cr);
      p_mxcp <= MPW'(mx_t) * MPW'(cp);
      p_mycr <= MPW'(my_t) * MPW'(cr);
      p_mzsr <= MPW'(mz_t) * MPW'(sr);
      my_m   <= my_t;
      mz_m   <= mz_t;
    end
  end

  // ------------------------------------------------------------------
  // Second multiply stage: floor the Q60 cross terms to Q30 and scale by
  // the samples; hy is complete here.
  // ------------------------------------------------------------------
  logic signed [TW-1:0] spsr_w, spcr_w;

  assign spsr_w = $signed(p_spsr[TW+29:30]);
  assign spcr_w = $signed(p_spcr[TW+29:30]);

  logic                  m2v;
  logic signed [MPW-1:0] q_myss, q_mzsc, mxcp_m;
  logic signed [HW-1:0]  hy;

  always_ff @(posedge clk) begin
    if (rst) begin
      m2v <= 1'b0;
    end else if (adv) begin
      m2v <= m1v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      q_myss <= MPW'(my_m) * MPW'(spsr_w);
      q_mzsc <= MPW'(mz_m) * MPW'(spcr_w);
      mxcp_m <= p_mxcp;
      hy     <= HW'(p_mycr) + HW'(p_mzsr);
    end
  end

  // ------------------------------------------------------------------
  // Sum stage: hx, and the vector (hx, -hy) whose angle is the heading.
  // ------------------------------------------------------------------
  logic                 sv;
  logic signed [VW-1:0] hx, ny;

  always_ff @(posedge clk) begin
    if (rst) begin
      sv <= 1'b0;
    end else if (adv) begin
      sv <= m2v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hx <= VW'(mxcp_m) + VW'(q_myss) - VW'(q_mzsc);
      ny <= -VW'(hy);
    end
  end

  // ------------------------------------------------------------------
  // Pre-rotation stage (index 0 of the vectoring arrays): a vector in the
  // left half plane is turned by a quarter turn so the vectoring CORDIC
  // converges. Stage k then performs iteration k-1, driving y to zero.
  // ------------------------------------------------------------------
  logic                 vv   [0:N];
  logic signed [VW-1:0] vx   [0:N];
  logic signed [VW-1:0] vy   [0:N];
  logic signed [ZW-1:0] vz   [0:N];
  logic                 vzero[0:N];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= N; k++) begin
        vv[k] <= 1'b0;
      end
    end else if (adv) begin
      vv[0] <= sv;
      for (int k = 1; k <= N; k++) begin
        vv[k] <= vv[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      vzero[0] <= (hx == '0) && (ny == '0);
      if (hx < 0) begin
        if (ny >= 0) begin
          vx[0] <= ny;
          vy[0] <= -hx;
          vz[0] <= HALF_PI_Q30;
        end else begin
          vx[0] <= -ny;
          vy[0] <= hx;
          vz[0] <= -HALF_PI_Q30;
        end
      end else begin
        vx[0] <= hx;
        vy[0] <= ny;
        vz[0] <= '0;
      end
      for (int k = 1; k <= N; k++) begin
        if (vy[k-1] >= 0) begin
          vx[k] <= vx[k-1] + (vy[k-1] >>> (k - 1));
          vy[k] <= vy[k-1] - (vx[k-1] >>> (k - 1));
          vz[k] <= vz[k-1] + atan_z(k - 1);
        end else begin
          vx[k] <= vx[k-1] - (vy[k-1] >>> (k - 1));
          vy[k] <= vy[k-1] + (vx[k-1] >>> (k - 1));
          vz[k] <= vz[k-1] - atan_z(k - 1);
        end
        vzero[k] <= vzero[k-1];
      end
    end
  end

  // ------------------------------------------------------------------
  // Output stage: wrap negative angles by a full turn and round half up
  // to Q13 in one add; a result that rounds to a full turn becomes zero.
  // ------------------------------------------------------------------
  logic signed [FW-1:0]  wrap_sum;
  logic [ANGLE_W-1:0]    head_q;

  always_comb begin
    if (vz[N] < 0) begin
      wrap_sum = FW'(vz[N]) + FW'(TWO_PI_Q30) + FW'(ROUND_Q30);
    end else begin
      wrap_sum = FW'(vz[N]) + FW'(ROUND_Q30);
    end
    head_q = wrap_sum[ANGLE_W+16:17];
  end

  logic               ov;
  logic [ANGLE_W-1:0] head_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (adv) begin
      ov <= vv[N];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (vzero[N] || (head_q >= TWO_PI_Q13)) begin
        head_r <= '0;
      end else begin
        head_r <= head_q;
      end
    end
  end

  // ------------------------------------------------------------------
  // Skid register: catches the last stage's beat when the consumer stalls,
  // so the pipeline can take one more beat before it has to hold.
  // ------------------------------------------------------------------
  logic [ANGLE_W-1:0] skid_heading;

  always_ff @(posedge clk) begin
    if (rst) begin
      skid_full <= 1'b0;
    end else if (skid_full) begin
      if (out_ready) begin
        skid_full <= 1'b0;
      end
    end else if (ov && !out_ready) begin
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_full) begin
      skid_heading <= head_r;
    end
  end

  assign out_valid = skid_full || ov;
  assign heading   = skid_full ? skid_heading : head_r;

`ifndef SYNTHESIS
  // The folded CORDIC start angle lies within a quarter turn.
  a_fold_range: assert property (@(posedge clk) disable iff (rst)
    rv[0] |-> (rz[0] <= HALF_PI_Q30) && (rz[0] >= -HALF_PI_Q30) &&
              (pz[0] <= HALF_PI_Q30) && (pz[0] >= -HALF_PI_Q30))
    else $error("folded angle outside a quarter turn");

  // A delivered heading is always below a full turn.
  a_heading_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (heading < TWO_PI_Q13))
    else $error("heading at or above a full turn");

  // A stalled result from the last stage lands in the skid register intact.
  a_skid_capture: assert property (@(posedge clk) disable iff (rst)
    (!skid_full && ov && !out_ready) |=>
      skid_full && (skid_heading == $past(head_r)))
    else $error("skid register missed a stalled beat");

  // While the skid register waits, the pipeline output holds still.
  a_pipe_hold: assert property (@(posedge clk) disable iff (rst)
    (skid_full && !out_ready) |=>
      skid_full && $stable(head_r) && $stable(ov) && $stable(skid_heading))
    else $error("pipeline moved while the skid register was full");
`endif

endmodule

/* sim/testbench.sv */
// Self-checking testbench for tilt_compensated_heading: directed and random samples
// through valid/ready, with headings predicted by an independent fixed-point CORDIC.
// Depends on tch_pkg and tilt_compensated_heading from the rtl folder.
module testbench;

  import tch_pkg::*;

  // The block is built with its default iteration count. The predictor follows it.
  localparam int STEPS = 16;
  localparam int STEP_CAP = 60;
  localparam int LATENCY = 2 * STEPS + 7;
  localparam int RANDOM_SAMPLES = 900;

  // Q30 angle constants, kept as 64-bit values so that the predictor's arithmetic
  // never has to think about sign extension from narrower vectors.
  localparam longint ANG_PI      = 64'sd3373259426;
  localparam longint ANG_HALF_PI = 64'sd1686629713;
  localparam longint ANG_TWO_PI  = 64'sd6746518852;
  localparam longint ROT_GAIN    = 64'sd652032874;
  localparam longint HALF_LSB_Q13 = 64'sd65536;
  localparam longint FULL_TURN_Q13 = 64'sd51472;
  // Pi in Q3.13, the largest angle magnitude a well-formed sample carries.
  localparam int PI_Q13 = 25735;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] roll;
    logic signed [ANGLE_W-1:0] pitch;
    logic signed [ANGLE_W-1:0] mx;
    logic signed [ANGLE_W-1:0] my;
    logic signed [ANGLE_W-1:0] mz;
  } sample_t;

  // One heading still owed by the block, together with the sample that caused it,
  // so that a mismatch report can show where it came from.
  typedef struct {
    sample_t           src;
    logic [ANGLE_W-1:0] heading;
  } owed_heading_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic signed [ANGLE_W-1:0] roll_angle = '0;
  logic signed [ANGLE_W-1:0] pitch_angle = '0;
  logic signed [ANGLE_W-1:0] mag_x = '0;
  logic signed [ANGLE_W-1:0] mag_y = '0;
  logic signed [ANGLE_W-1:0] mag_z = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [ANGLE_W-1:0]        heading;

  // Samples not yet offered to the block, and headings the block still owes us.
  sample_t       pending_samples [$];
  owed_heading_t heading_queue [$];

  // atan(2^-i) in Q30, built once at time zero from a Taylor series.
  longint atan_lut [0:STEP_CAP-1];

  int unsigned samples_sent = 0;
  int unsigned headings_seen = 0;
  int unsigned zero_headings = 0;
  int unsigned directed_count = 0;
  int unsigned mismatch_count = 0;

  always #2 clk = ~clk;

  tilt_compensated_heading #(
    .CORDIC_STEPS(STEPS)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .roll_angle (roll_angle),
    .pitch_angle(pitch_angle),
    .mag_x      (mag_x),
    .mag_y      (mag_y),
    .mag_z      (mag_z),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .heading    (heading)
  );

  // ---------------------------------------------------------------------------
  // Heading predictor
  // ---------------------------------------------------------------------------

  // Rotation-mode CORDIC: sine and cosine of a Q3.13 angle, both in Q30. Angles
  // past a quarter turn are folded by half a turn and the results negated; this
  // also covers inputs that lie outside -pi..pi.
  function automatic void sine_cosine_q30(input logic signed [ANGLE_W-1:0] ang,
                                          output longint s, output longint c);
    longint z;
    longint x;
    longint y;
    longint dx;
    longint dy;
    bit     flip;
    z = longint'(ang) * 131072;
    x = ROT_GAIN;
    y = 0;
    flip = 1'b0;
    if (z > ANG_HALF_PI) begin
      z = z - ANG_PI;
      flip = 1'b1;
    end else if (z < -ANG_HALF_PI) begin
      z = z + ANG_PI;
      flip = 1'b1;
    end
    for (int i = 0; i < STEPS && i < STEP_CAP; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - atan_lut[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + atan_lut[i];
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    s = y;
    c = x;
  endfunction

  // Vectoring-mode CORDIC: atan2(y, x) in Q30. A vector in the left half plane is
  // first turned a quarter turn toward the right half plane so the iterations
  // converge; the origin gives zero.
  function automatic longint vector_angle_q30(input longint x, input longint y);
    longint z;
    longint t;
    longint dx;
    longint dy;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y;
        y = -t;
        z = ANG_HALF_PI;
      end else begin
        x = -y;
        y = t;
        z = -ANG_HALF_PI;
      end
    end
    for (int i = 0; i < STEPS && i < STEP_CAP; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x = x + dx;
        y = y - dy;
        z = z + atan_lut[i];
      end else begin
        x = x - dx;
        y = y + dy;
        z = z - atan_lut[i];
      end
    end
    return z;
  endfunction

  // Tilt compensation followed by the heading angle, wrapped to 0..2pi in Q3.13.
  function automatic logic [ANGLE_W-1:0] predict_heading(input sample_t s);
    longint sin_r;
    longint cos_r;
    longint sin_p;
    longint cos_p;
    longint sp_sr;
    longint sp_cr;
    longint h_x;
    longint h_y;
    longint z;
    longint rounded;
    sine_cosine_q30(s.roll, sin_r, cos_r);
    sine_cosine_q30(s.pitch, sin_p, cos_p);
    // Products of two Q30 values are floored back to Q30.
    sp_sr = (sin_p * sin_r) >>> 30;
    sp_cr = (sin_p * cos_r) >>> 30;
    h_y = longint'(s.my) * cos_r + longint'(s.mz) * sin_r;
    h_x = longint'(s.mx) * cos_p + longint'(s.my) * sp_sr - longint'(s.mz) * sp_cr;
    z = vector_angle_q30(h_x, -h_y);
    if (z < 0) z = z + ANG_TWO_PI;
    if (z < 0) z = 0;
    // Round half up from Q30 to Q13; a value that rounds to a full turn wraps to 0.
    rounded = (z + HALF_LSB_Q13) >>> 17;
    if (rounded >= FULL_TURN_Q13) rounded = 0;
    return rounded[ANGLE_W-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic sample_t make_sample(input int r, input int p, input int x,
                                          input int y, input int z);
    sample_t s;
    s.roll = r[ANGLE_W-1:0];
    s.pitch = p[ANGLE_W-1:0];
    s.mx = x[ANGLE_W-1:0];
    s.my = y[ANGLE_W-1:0];
    s.mz = z[ANGLE_W-1:0];
    return s;
  endfunction

  function automatic int any_word();
    return int'($signed(16'($urandom)));
  endfunction

  function automatic int well_formed_angle();
    return int'($urandom_range(0, 2 * PI_Q13)) - PI_Q13;
  endfunction

  // Most random samples are physically sensible: angles within -pi..pi and any
  // field strength. The rest aim at the corners: angles anywhere in the 16-bit
  // range, tiny fields around the zero vector, and tilt close to a quarter turn
  // where the angle folding switches over.
  function automatic sample_t random_sample();
    int kind;
    int r;
    int p;
    kind = $urandom_range(0, 9);
    case (kind)
      7: begin
        return make_sample(any_word(), any_word(), any_word(), any_word(), any_word());
      end
      8: begin
        return make_sample(well_formed_angle(), well_formed_angle(),
                           int'($urandom_range(0, 8)) - 4, int'($urandom_range(0, 8)) - 4,
                           int'($urandom_range(0, 8)) - 4);
      end
      9: begin
        r = int'($urandom_range(12860, 12876));
        p = int'($urandom_range(12860, 12876));
        if ($urandom_range(0, 1) == 1) r = -r;
        if ($urandom_range(0, 1) == 1) p = -p;
        return make_sample(r, p, any_word(), any_word(), any_word());
      end
      default: begin
        return make_sample(well_formed_angle(), well_formed_angle(),
                           any_word(), any_word(), any_word());
      end
    endcase
  endfunction

  // Wait before the next beat on one side. Each side has its own burst flag that
  // flips now and then; while it is set the side never idles, so long runs of
  // back-to-back beats alternate with stretches of random gaps.
  function automatic int unsigned idle_cycles(inout bit burst);
    if ($urandom_range(0, 47) == 0) burst = ~burst;
    if (burst) return 0;
    return $urandom_range(0, 12);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offers one sample at a time, holds it until the block takes the beat,
  // then waits its drawn gap before offering the next. Every accepted beat gets
  // its heading predicted right away and queued.
  // ---------------------------------------------------------------------------
  int unsigned send_gap = 0;
  bit          send_burst = 1'b0;

  always @(posedge clk) begin : sample_driver
    sample_t     s;
    bit          holding;
    owed_heading_t owed;
    if (rst) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && in_ready) begin
        owed.src = {roll_angle, pitch_angle, mag_x, mag_y, mag_z};
        owed.heading = predict_heading(owed.src);
        heading_queue.push_back(owed);
        samples_sent++;
      end
      // A beat that has not been taken must stay on the bus unchanged.
      holding = in_valid && !in_ready;
      if (!holding) begin
        if (send_gap > 0) begin
          in_valid <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (pending_samples.size() != 0) begin
          s = pending_samples.pop_front();
          roll_angle <= s.roll;
          pitch_angle <= s.pitch;
          mag_x <= s.mx;
          mag_y <= s.my;
          mag_z <= s.mz;
          in_valid <= 1'b1;
          send_gap <= idle_cycles(send_burst);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: takes result beats with a random stall before each one and compares
  // every heading with the oldest prediction. A heading nobody asked for is an
  // error too.
  // ---------------------------------------------------------------------------
  int unsigned recv_stall = 0;
  bit          recv_burst = 1'b0;

  always @(posedge clk) begin : heading_monitor
    owed_heading_t want;
    int unsigned   hold;
    if (rst) begin
      out_ready <= 1'b0;
      recv_stall <= 0;
    end else begin
      hold = recv_stall;
      if (out_valid && out_ready) begin
        headings_seen++;
        if (heading == '0) zero_headings++;
        if (heading_queue.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected heading beat: %0d at %0t", heading, $realtime);
        end else begin
          want = heading_queue.pop_front();
          if (heading !== want.heading) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("heading mismatch: roll %0d pitch %0d mag %0d/%0d/%0d expected %0d got %0d",
                       want.src.roll, want.src.pitch, want.src.mx, want.src.my, want.src.mz,
                       want.heading, heading);
          end
        end
        hold = idle_cycles(recv_burst);
      end else if (recv_stall > 0) begin
        hold = recv_stall - 1;
      end
      recv_stall <= hold;
      out_ready <= (hold == 0);
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : main_sequence
    longint unsigned series;
    longint unsigned term;
    int              e;
    // Arctangent table: entry 0 is pi/4; the rest sum the Taylor series of
    // atan(2^-i) in Q62 with truncated terms, then round half up to Q30.
    for (int i = 0; i < STEP_CAP; i++) begin
      if (i == 0) begin
        atan_lut[i] = 64'sh3243F6A9;
      end else begin
        series = 0;
        for (int k = 0; k < 64; k++) begin
          e = 62 - (2 * k + 1) * i;
          if (e < 0) break;
          term = (64'd1 << e) / longint'(2 * k + 1);
          if (k % 2 == 1) series = series - term;
          else series = series + term;
        end
        atan_lut[i] = longint'((series + 64'd2147483648) >> 32);
      end
    end

    // Directed samples. Zero field, with and without tilt, must give heading zero.
    pending_samples.push_back(make_sample(0, 0, 0, 0, 0));
    pending_samples.push_back(make_sample(5000, -3000, 0, 0, 0));
    // Level compass pointing along each axis, both senses.
    pending_samples.push_back(make_sample(0, 0, 1000, 0, 0));
    pending_samples.push_back(make_sample(0, 0, -1000, 0, 0));   // negative x alone: pi
    pending_samples.push_back(make_sample(0, 0, -32768, 0, 0));
    pending_samples.push_back(make_sample(0, 0, -1, 0, 0));
    pending_samples.push_back(make_sample(0, 0, 0, 1000, 0));
    pending_samples.push_back(make_sample(0, 0, 0, -1000, 0));
    // Negative horizontal x with the other component on either side.
    pending_samples.push_back(make_sample(0, 0, -1000, 500, 0));
    pending_samples.push_back(make_sample(0, 0, -1000, -500, 0));
    // A heading a quarter LSB short of a full turn rounds up and wraps to zero.
    pending_samples.push_back(make_sample(0, 0, 32767, 1, 0));
    // Field and angle extremes; the extreme angles lie beyond pi and get folded.
    pending_samples.push_back(make_sample(32767, 32767, 32767, 32767, 32767));
    pending_samples.push_back(make_sample(-32768, -32768, -32768, -32768, -32768));
    pending_samples.push_back(make_sample(0, 0, 32767, 32767, 32767));
    pending_samples.push_back(make_sample(0, 0, -32768, -32768, -32768));
    pending_samples.push_back(make_sample(-1, 1, 32767, -32768, 32767));
    // Angles of about plus and minus pi.
    pending_samples.push_back(make_sample(25736, -25736, 1200, -800, 300));
    // Just past and just short of a quarter turn, where folding starts.
    pending_samples.push_back(make_sample(12868, 12867, 500, 500, 500));
    pending_samples.push_back(make_sample(-12868, -12867, -700, 900, -400));
    // About one radian of tilt in each sense.
    pending_samples.push_back(make_sample(8192, -8192, 100, 200, 300));
    directed_count = pending_samples.size();

    for (int n = 0; n < RANDOM_SAMPLES; n++)
      pending_samples.push_back(random_sample());

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Run until every sample is taken and every heading has come back, then give
    // the pipeline a full latency more so that stray beats would still show up.
    while (pending_samples.size() != 0 || in_valid || heading_queue.size() != 0)
      @(posedge clk);
    repeat (LATENCY + 16) @(posedge clk);

    $display("%0d samples sent (%0d directed), %0d headings checked, %0d of them zero",
             samples_sent, directed_count, headings_seen, zero_headings);
    $display("%0d heading errors", mismatch_count);
    if (mismatch_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run with every gap and stall at its
  // longest.
  initial begin : watchdog
    #(4 * 300000);
    $display("timeout with %0d headings outstanding", heading_queue.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
